FILE: rtl/nps3d_pkg.sv
package nps3d_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = 34;
    localparam int POINT_W    = 3 * COORD_W;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
    } nps3d_in_t;

    typedef struct packed {
        logic               found;
        logic [7:0]         nearest_index;
        logic [DIST_W-1:0]  nearest_sq_distance;
    } nps3d_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } nps3d_state_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             start;
        logic             out_load;
        logic [IDX_W-1:0] addr;
    } nps3d_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } nps3d_status_t;

endpackage

FILE: rtl/nearest_point_search_3d_top.sv
// Stores up to 256 three-dimensional points with signed 16-bit coordinates and answers
// nearest-point queries by squared Euclidean distance, ties going to the lowest load index.
// Opcode 0 clears the set and opcode 1 loads a point, each with no result; loads beyond
// capacity and opcode 3 are dropped. Opcode 2 gives one result transfer once the single
// distance unit has read every stored point, one point per cycle, from the point memory
// and passed it through four pipeline stages to the final compare.
// A query on an empty set returns found at zero with zero index and distance.
module nearest_point_search_3d_top
    import nps3d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  nps3d_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output nps3d_out_t out_data
);

    nps3d_cmd_t    cmd;
    nps3d_status_t status;

    nps3d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (in_data.opcode),
        .status   (status),
        .cmd      (cmd)
    );

    nps3d_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/nps3d_ctrl.sv
module nps3d_ctrl
    import nps3d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    opcode,
    input  nps3d_status_t status,
    output nps3d_cmd_t    cmd
);

    nps3d_state_t     state_reg;
    nps3d_state_t     state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0] scan_idx_next;
    logic             not_full;

    assign not_full = (count_reg < CNT_W'(MAX_POINTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (opcode == OP_QUERY))
                begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((scan_idx_reg + CNT_W'(1)) == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        cmd.addr      = count_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (not_full)
                            begin
                                cmd.wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_QUERY:
                        begin
                            cmd.start     = 1'b1;
                            scan_idx_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en     = 1'b1;
                cmd.addr      = scan_idx_reg[IDX_W-1:0];
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
                cmd.out_load = 1'b0;
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("Point count exceeds capacity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg < count_reg))
        else $error("Scan address beyond the stored points.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !status.busy)
        else $error("Result taken while the distance pipeline is busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (count_reg == $past(count_reg)))
        else $error("Point count changed during a scan.");

endmodule

FILE: rtl/nps3d_dpath.sv
module nps3d_dpath
    import nps3d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  nps3d_in_t     in_data,
    input  nps3d_cmd_t    cmd,
    output nps3d_status_t status,
    input  logic          out_ready,
    output logic          out_valid,
    output nps3d_out_t    out_data
);

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (d[COORD_W])
        begin
            abs_diff = COORD_W'(-d);
        end
        else
        begin
            abs_diff = d[COORD_W-1:0];
        end
    endfunction

    logic [POINT_W-1:0]        mem [MAX_POINTS];
    logic [POINT_W-1:0]        rd_data_reg;
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;
    logic signed [COORD_W-1:0] qz_reg;

    logic                      s0_valid_reg;
    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic                      s3_valid_reg;
    logic [IDX_W-1:0]          s0_idx_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    logic [IDX_W-1:0]          s3_idx_reg;
    logic [COORD_W-1:0]        dx_reg;
    logic [COORD_W-1:0]        dy_reg;
    logic [COORD_W-1:0]        dz_reg;
    logic [SQ_W-1:0]           sx_reg;
    logic [SQ_W-1:0]           sy_reg;
    logic [SQ_W-1:0]           sz_reg;
    logic [DIST_W-1:0]         sum_reg;

    logic                      have_reg;
    logic [IDX_W-1:0]          best_i_reg;
    logic [DIST_W-1:0]         best_d_reg;
    logic                      out_valid_reg;
    nps3d_out_t                out_data_reg;
    logic                      better;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr] <= {in_data.coord_x, in_data.coord_y, in_data.coord_z};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qx_reg <= in_data.coord_x;
            qy_reg <= in_data.coord_y;
            qz_reg <= in_data.coord_z;
        end
        s0_idx_reg <= cmd.addr;
        s1_idx_reg <= s0_idx_reg;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        dx_reg     <= abs_diff(qx_reg, rd_data_reg[3*COORD_W-1:2*COORD_W]);
        dy_reg     <= abs_diff(qy_reg, rd_data_reg[2*COORD_W-1:COORD_W]);
        dz_reg     <= abs_diff(qz_reg, rd_data_reg[COORD_W-1:0]);
        sx_reg     <= dx_reg * dx_reg;
        sy_reg     <= dy_reg * dy_reg;
        sz_reg     <= dz_reg * dz_reg;
        sum_reg    <= DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
        if (cmd.out_load)
        begin
            out_data_reg.found               <= have_reg;
            out_data_reg.nearest_index       <= 8'(best_i_reg);
            out_data_reg.nearest_sq_distance <= best_d_reg;
        end
    end

    assign better = s3_valid_reg && (!have_reg || (sum_reg < best_d_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            have_reg      <= 1'b0;
            best_i_reg    <= '0;
            best_d_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= cmd.rd_en;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (cmd.start)
            begin
                have_reg   <= 1'b0;
                best_i_reg <= '0;
                best_d_reg <= '0;
            end
            else if (better)
            begin
                have_reg   <= 1'b1;
                best_i_reg <= s3_idx_reg;
                best_d_reg <= sum_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.busy     = s0_valid_reg | s1_valid_reg | s2_valid_reg | s3_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.busy)
        else $error("Result loaded before the last distance was compared.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (!have_reg && (best_d_reg == '0)))
        else $error("Best match not cleared at the start of a query.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && have_reg && !cmd.start) |=> (best_d_reg <= $past(best_d_reg)))
        else $error("Best distance grew during a scan.");

endmodule
